[hdl/stbs_pkg.sv]
// ----------------------------------------------------------------------------
// stbs_pkg
// shared types and constants of the environment map bilinear sampler
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int CORDIC_STEPS = 22;
    localparam int SQRT_STEPS   = 24;
    localparam int SQ_W         = 48;
    localparam int AXY_W        = 36;
    localparam int BXY_W        = 44;
    localparam int ACC_W        = 26;
    localparam int ARC_W        = 22;
    localparam int QDEPTH       = 4;
    localparam int STORE_DEPTH  = 65536;
    localparam int HALF_TURN    = 8388608;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic [15:0]             adr;
        logic [23:0]             rgb;
        logic signed [15:0]      y;
        logic signed [AXY_W-1:0] apx;
        logic signed [AXY_W-1:0] apy;
        logic signed [ACC_W-1:0] ang;
        logic                    az;
        logic [31:0]             sumsq;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // atan(2^-i) in units of 2^-24 turn
    function automatic logic [ARC_W-1:0] arc_lut(input int i);
        logic [ARC_W-1:0] r;
        case (i)
            0:  r = 22'd2097152;
            1:  r = 22'd1238021;
            2:  r = 22'd654136;
            3:  r = 22'd332050;
            4:  r = 22'd166669;
            5:  r = 22'd83416;
            6:  r = 22'd41718;
            7:  r = 22'd20860;
            8:  r = 22'd10430;
            9:  r = 22'd5215;
            10: r = 22'd2608;
            11: r = 22'd1304;
            12: r = 22'd652;
            13: r = 22'd326;
            14: r = 22'd163;
            15: r = 22'd81;
            16: r = 22'd41;
            17: r = 22'd20;
            18: r = 22'd10;
            19: r = 22'd5;
            20: r = 22'd3;
            21: r = 22'd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[hdl/stbs_front.sv]
// ----------------------------------------------------------------------------
// stbs_front
// input stage: takes items, prepares the azimuth rotation and radius square
// ----------------------------------------------------------------------------
module stbs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_kind,
    input  logic [15:0]        i_texel_address,
    input  logic [23:0]        i_texel_rgb,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_dir_z,
    input  stbs_pkg::t_qstat   i_qstat,
    output logic               o_qpush,
    output stbs_pkg::t_qent    o_qent
);
    import stbs_pkg::*;

    logic               r_fv;
    logic               r_kind;
    logic [15:0]        r_adr;
    logic [23:0]        r_rgb;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_z;
    logic               w_acc;
    logic signed [31:0] w_xx;
    logic signed [31:0] w_zz;
    logic signed [AXY_W-1:0] w_px;
    logic signed [AXY_W-1:0] w_pz;

    assign o_qpush = r_fv && !i_qstat.full;
    assign o_full  = r_fv && i_qstat.full;
    assign w_acc   = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_acc) begin
            r_fv <= 1'b1;
        end else if (o_qpush) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_kind <= i_kind;
            r_adr  <= i_texel_address;
            r_rgb  <= i_texel_rgb;
            r_x    <= i_dir_x;
            r_y    <= i_dir_y;
            r_z    <= i_dir_z;
        end
    end

    always_comb begin
        w_xx = r_x * r_x;
        w_zz = r_z * r_z;
        w_px = {{(AXY_W-32){r_x[15]}}, r_x, 16'b0};
        w_pz = {{(AXY_W-32){r_z[15]}}, r_z, 16'b0};
        o_qent.kind  = r_kind;
        o_qent.adr   = r_adr;
        o_qent.rgb   = r_rgb;
        o_qent.y     = r_y;
        o_qent.sumsq = $unsigned(w_xx) + $unsigned(w_zz);
        o_qent.apx   = w_px;
        o_qent.apy   = w_pz;
        o_qent.ang   = '0;
        o_qent.az    = 1'b0;
        // on the x axis the angle is fixed, the rotations are skipped
        if (r_z == 16'sd0) begin
            o_qent.az  = 1'b1;
            o_qent.ang = r_x[15] ? ACC_W'(HALF_TURN) : '0;
        end else if (r_x[15]) begin
            o_qent.ang = r_z[15] ? -ACC_W'(HALF_TURN) : ACC_W'(HALF_TURN);
            o_qent.apx = -w_px;
            o_qent.apy = -w_pz;
        end
    end

endmodule

[hdl/stbs_fifo.sv]
// ----------------------------------------------------------------------------
// stbs_fifo
// short queue between the front stage and the sampling pipeline
// ----------------------------------------------------------------------------
module stbs_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  stbs_pkg::t_qent  i_ent,
    input  logic             i_pop,
    output stbs_pkg::t_qent  o_ent,
    output stbs_pkg::t_qstat o_stat
);
    import stbs_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_qent         r_mem [0:QDEPTH-1];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_stat.full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_wr  = i_push && !o_stat.full;
    assign w_rd  = i_pop && !o_stat.empty;
    assign o_ent = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            if (w_wr && !w_rd) r_cnt <= r_cnt + 1'b1;
            else if (w_rd && !w_wr) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_ent;
    end

endmodule

[hdl/stbs_back.sv]
// ----------------------------------------------------------------------------
// stbs_back
// sampling pipeline: square root, two cordic chains, coordinates, texel
// store and bilinear blend, with the result register
// ----------------------------------------------------------------------------
module stbs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stbs_pkg::t_qent  i_qent,
    input  stbs_pkg::t_qstat i_qstat,
    output logic             o_qpop,
    input  logic [8:0]       i_w,
    input  logic [8:0]       i_h,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [15:0]      o_red,
    output logic [15:0]      o_green,
    output logic [15:0]      o_blue
);
    import stbs_pkg::*;

    localparam int NS = SQRT_STEPS;
    localparam int NB = CORDIC_STEPS;

    logic w_adv;

    // square root phase, azimuth cordic runs alongside
    logic                    r_sv   [0:NS];
    logic                    r_sk   [0:NS];
    logic [15:0]             r_sadr [0:NS];
    logic [23:0]             r_srgb [0:NS];
    logic signed [15:0]      r_sy   [0:NS];
    logic [SQ_W-1:0]         r_sn   [0:NS];
    logic [SQ_W-1:0]         r_sr   [0:NS];
    logic signed [AXY_W-1:0] r_apx  [0:NS];
    logic signed [AXY_W-1:0] r_apy  [0:NS];
    logic signed [ACC_W-1:0] r_aac  [0:NS];
    logic                    r_az   [0:NS];
    logic [SQ_W-1:0]         n_sn   [1:NS];
    logic [SQ_W-1:0]         n_sr   [1:NS];
    logic signed [AXY_W-1:0] n_apx  [1:NS];
    logic signed [AXY_W-1:0] n_apy  [1:NS];
    logic signed [ACC_W-1:0] n_aac  [1:NS];

    // elevation cordic phase
    logic                    r_bv   [0:NB];
    logic                    r_bk   [0:NB];
    logic [15:0]             r_badr [0:NB];
    logic [23:0]             r_brgb [0:NB];
    logic signed [ACC_W-1:0] r_bang [0:NB];
    logic signed [BXY_W-1:0] r_bpx  [0:NB];
    logic signed [BXY_W-1:0] r_bpy  [0:NB];
    logic signed [ACC_W-1:0] r_bac  [0:NB];
    logic                    r_bz   [0:NB];
    logic signed [BXY_W-1:0] n_bpx  [1:NB];
    logic signed [BXY_W-1:0] n_bpy  [1:NB];
    logic signed [ACC_W-1:0] n_bac  [1:NB];

    logic        r_t1v, r_t2v, r_t3v, r_t4v, r_t5v, r_t6v;
    logic        r_t1k, r_t2k, r_t3k, r_t4k, r_t5k, r_t6k;
    logic [15:0] r_t1adr, r_t2adr, r_t3adr, r_t4adr;
    logic [23:0] r_t1rgb, r_t2rgb, r_t3rgb, r_t4rgb;
    logic [16:0] r_t1u, r_t1v_c, n_t1u, n_t1v;
    logic [25:0] r_t2fx, r_t2fy;
    logic [32:0] r_t3wt [0:3];
    logic [32:0] r_t4wt [0:3];
    logic [32:0] r_t5wt [0:3];
    logic [32:0] n_wt   [0:3];
    logic [18:0] r_t3r0, r_t3r1;
    logic [9:0]  r_t3x0, r_t3x1;
    logic [15:0] r_t4ad [0:3];
    logic [23:0] r_t5tex [0:3];
    logic [40:0] r_t6p [0:2][0:3];

    logic [23:0] r_mem0 [0:STORE_DEPTH-1];
    logic [23:0] r_mem1 [0:STORE_DEPTH-1];

    logic        r_ov;
    logic [15:0] r_red, r_green, r_blue;

    logic [9:0]  w_x0, w_y0, w_x1, w_y1;
    logic [15:0] w_ax, w_ay;
    logic [16:0] w_iax, w_iay;
    logic [8:0]  w_wm1, w_hm1;
    logic [40:0] w_sum [0:2];

    assign w_adv   = !r_ov || i_pop;
    assign o_qpop  = w_adv && !i_qstat.empty;
    assign o_empty = !r_ov;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
    assign w_wm1   = i_w - 9'd1;
    assign w_hm1   = i_h - 9'd1;

    // root and azimuth steps
    always_comb begin
        logic [SQ_W-1:0] bt;
        logic [SQ_W-1:0] tr;
        logic signed [AXY_W-1:0] dx;
        logic signed [AXY_W-1:0] dy;
        logic signed [ACC_W-1:0] da;
        for (int j = 0; j < NS; j++) begin
            bt = SQ_W'(1) << (SQ_W - 2 - 2 * j);
            tr = r_sr[j] + bt;
            if (r_sn[j] >= tr) begin
                n_sn[j+1] = r_sn[j] - tr;
                n_sr[j+1] = (r_sr[j] >> 1) + bt;
            end else begin
                n_sn[j+1] = r_sn[j];
                n_sr[j+1] = r_sr[j] >> 1;
            end
            n_apx[j+1] = r_apx[j];
            n_apy[j+1] = r_apy[j];
            n_aac[j+1] = r_aac[j];
            dx = r_apy[j] >>> j;
            dy = r_apx[j] >>> j;
            da = $signed(ACC_W'(arc_lut(j)));
            if (j < NB && !r_az[j]) begin
                if (r_apy[j] >= 0) begin
                    n_apx[j+1] = r_apx[j] + dx;
                    n_apy[j+1] = r_apy[j] - dy;
                    n_aac[j+1] = r_aac[j] + da;
                end else begin
                    n_apx[j+1] = r_apx[j] - dx;
                    n_apy[j+1] = r_apy[j] + dy;
                    n_aac[j+1] = r_aac[j] - da;
                end
            end
        end
    end

    // elevation steps
    always_comb begin
        logic signed [BXY_W-1:0] dx;
        logic signed [BXY_W-1:0] dy;
        logic signed [ACC_W-1:0] da;
        for (int k = 0; k < NB; k++) begin
            dx = r_bpy[k] >>> k;
            dy = r_bpx[k] >>> k;
            da = $signed(ACC_W'(arc_lut(k)));
            n_bpx[k+1] = r_bpx[k];
            n_bpy[k+1] = r_bpy[k];
            n_bac[k+1] = r_bac[k];
            if (!r_bz[k]) begin
                if (r_bpy[k] >= 0) begin
                    n_bpx[k+1] = r_bpx[k] + dx;
                    n_bpy[k+1] = r_bpy[k] - dy;
                    n_bac[k+1] = r_bac[k] + da;
                end else begin
                    n_bpx[k+1] = r_bpx[k] - dx;
                    n_bpy[k+1] = r_bpy[k] + dy;
                    n_bac[k+1] = r_bac[k] - da;
                end
            end
        end
    end

    // angles to texture coordinates, rounded and clamped to 0..1
    always_comb begin
        logic signed [ACC_W-1:0] ra;
        logic signed [ACC_W-1:0] rb;
        logic signed [ACC_W-1:0] ur;
        logic signed [ACC_W-1:0] vr;
        ra = r_bang[NB] + $signed(ACC_W'(128));
        rb = r_bac[NB] + $signed(ACC_W'(64));
        ur = $signed(ACC_W'(32768)) + (ra >>> 8);
        vr = $signed(ACC_W'(32768)) - (rb >>> 7);
        if (ur < 0) n_t1u = '0;
        else if (ur > $signed(ACC_W'(65536))) n_t1u = 17'h10000;
        else n_t1u = ur[16:0];
        if (vr < 0) n_t1v = '0;
        else if (vr > $signed(ACC_W'(65536))) n_t1v = 17'h10000;
        else n_t1v = vr[16:0];
    end

    // neighbor indexes and weights
    always_comb begin
        w_x0  = r_t2fx[25:16];
        w_ax  = r_t2fx[15:0];
        w_y0  = r_t2fy[25:16];
        w_ay  = r_t2fy[15:0];
        // neighbor saturates at the last column or row
        w_x1  = (11'(w_x0) + 11'd1 < 11'(i_w)) ? w_x0 + 10'd1 : 10'(w_wm1);
        w_y1  = (11'(w_y0) + 11'd1 < 11'(i_h)) ? w_y0 + 10'd1 : 10'(w_hm1);
        w_iax = 17'h10000 - 17'(w_ax);
        w_iay = 17'h10000 - 17'(w_ay);
        n_wt[0] = 33'(34'(w_iax) * 34'(w_iay));
        n_wt[1] = 33'(34'(w_ax) * 34'(w_iay));
        n_wt[2] = 33'(34'(w_iax) * 34'(w_ay));
        n_wt[3] = 33'(34'(w_ax) * 34'(w_ay));
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = r_t6p[c][0] + r_t6p[c][1] + r_t6p[c][2] + r_t6p[c][3]
                     + 41'h800000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= NS; j++) r_sv[j] <= 1'b0;
            for (int k = 0; k <= NB; k++) r_bv[k] <= 1'b0;
            r_t1v <= 1'b0;
            r_t2v <= 1'b0;
            r_t3v <= 1'b0;
            r_t4v <= 1'b0;
            r_t5v <= 1'b0;
            r_t6v <= 1'b0;
            r_ov  <= 1'b0;
        end else if (w_adv) begin
            r_sv[0] <= !i_qstat.empty;
            for (int j = 0; j < NS; j++) r_sv[j+1] <= r_sv[j];
            r_bv[0] <= r_sv[NS];
            for (int k = 0; k < NB; k++) r_bv[k+1] <= r_bv[k];
            r_t1v <= r_bv[NB];
            r_t2v <= r_t1v;
            r_t3v <= r_t2v;
            r_t4v <= r_t3v;
            r_t5v <= r_t4v;
            r_t6v <= r_t5v;
            r_ov  <= r_t6v && (r_t6k == KIND_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sk[0]   <= i_qent.kind;
            r_sadr[0] <= i_qent.adr;
            r_srgb[0] <= i_qent.rgb;
            r_sy[0]   <= i_qent.y;
            r_sn[0]   <= {i_qent.sumsq, 16'b0};
            r_sr[0]   <= '0;
            r_apx[0]  <= i_qent.apx;
            r_apy[0]  <= i_qent.apy;
            r_aac[0]  <= i_qent.ang;
            r_az[0]   <= i_qent.az;
            for (int j = 0; j < NS; j++) begin
                r_sk[j+1]   <= r_sk[j];
                r_sadr[j+1] <= r_sadr[j];
                r_srgb[j+1] <= r_srgb[j];
                r_sy[j+1]   <= r_sy[j];
                r_sn[j+1]   <= n_sn[j+1];
                r_sr[j+1]   <= n_sr[j+1];
                r_apx[j+1]  <= n_apx[j+1];
                r_apy[j+1]  <= n_apy[j+1];
                r_aac[j+1]  <= n_aac[j+1];
                r_az[j+1]   <= r_az[j];
            end

            r_bk[0]   <= r_sk[NS];
            r_badr[0] <= r_sadr[NS];
            r_brgb[0] <= r_srgb[NS];
            r_bang[0] <= r_aac[NS];
            r_bpx[0]  <= $signed({{(BXY_W-41){1'b0}}, r_sr[NS][24:0], 16'b0});
            r_bpy[0]  <= $signed({{(BXY_W-40){r_sy[NS][15]}}, r_sy[NS], 24'b0});
            r_bac[0]  <= '0;
            r_bz[0]   <= (r_sy[NS] == 16'sd0);
            for (int k = 0; k < NB; k++) begin
                r_bk[k+1]   <= r_bk[k];
                r_badr[k+1] <= r_badr[k];
                r_brgb[k+1] <= r_brgb[k];
                r_bang[k+1] <= r_bang[k];
                r_bpx[k+1]  <= n_bpx[k+1];
                r_bpy[k+1]  <= n_bpy[k+1];
                r_bac[k+1]  <= n_bac[k+1];
                r_bz[k+1]   <= r_bz[k];
            end

            r_t1k   <= r_bk[NB];
            r_t1adr <= r_badr[NB];
            r_t1rgb <= r_brgb[NB];
            r_t1u   <= n_t1u;
            r_t1v_c <= n_t1v;

            r_t2k   <= r_t1k;
            r_t2adr <= r_t1adr;
            r_t2rgb <= r_t1rgb;
            r_t2fx  <= 26'(r_t1u) * 26'(w_wm1);
            r_t2fy  <= 26'(r_t1v_c) * 26'(w_hm1);

            r_t3k   <= r_t2k;
            r_t3adr <= r_t2adr;
            r_t3rgb <= r_t2rgb;
            r_t3r0  <= 19'(w_y0) * 19'(i_w);
            r_t3r1  <= 19'(w_y1) * 19'(i_w);
            r_t3x0  <= w_x0;
            r_t3x1  <= w_x1;
            for (int q = 0; q < 4; q++) r_t3wt[q] <= n_wt[q];

            r_t4k   <= r_t3k;
            r_t4adr <= r_t3adr;
            r_t4rgb <= r_t3rgb;
            r_t4ad[0] <= 16'(r_t3r0 + 19'(r_t3x0));
            r_t4ad[1] <= 16'(r_t3r0 + 19'(r_t3x1));
            r_t4ad[2] <= 16'(r_t3r1 + 19'(r_t3x0));
            r_t4ad[3] <= 16'(r_t3r1 + 19'(r_t3x1));
            for (int q = 0; q < 4; q++) r_t4wt[q] <= r_t3wt[q];

            r_t5k <= r_t4k;
            for (int q = 0; q < 4; q++) r_t5wt[q] <= r_t4wt[q];

            r_t6k <= r_t5k;
            for (int c = 0; c < 3; c++) begin
                for (int q = 0; q < 4; q++) begin
                    r_t6p[c][q] <= 41'(r_t5tex[q][23-8*c -: 8]) * 41'(r_t5wt[q]);
                end
            end

            r_red   <= w_sum[0][39:24];
            r_green <= w_sum[1][39:24];
            r_blue  <= w_sum[2][39:24];
        end
    end

    // texel store, two copies for four reads a cycle; loads write in order
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t5tex[0] <= r_mem0[r_t4ad[0]];
            r_t5tex[1] <= r_mem0[r_t4ad[1]];
            r_t5tex[2] <= r_mem1[r_t4ad[2]];
            r_t5tex[3] <= r_mem1[r_t4ad[3]];
            if (r_t4v && r_t4k == KIND_LOAD) begin
                r_mem0[r_t4adr] <= r_t4rgb;
                r_mem1[r_t4adr] <= r_t4rgb;
            end
        end
    end

endmodule

[hdl/sphere_texture_bilinear_sample.sv]
// ----------------------------------------------------------------------------
// sphere_texture_bilinear_sample
// equirectangular environment map lookup with bilinear filtering
// ----------------------------------------------------------------------------
// path: a sample result reaches the outputs after the 24-step square root and
// the 22-step elevation cordic, then the coordinate, store and blend stages
// throughput: one item per cycle while results are popped
// reset: synchronous, active low; clears the queues and restores width and
// height to 256, the texel store keeps its contents and needs loading
module sphere_texture_bilinear_sample #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_kind,
    input  logic [15:0]        i_texel_address,
    input  logic [23:0]        i_texel_rgb,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_dir_z,
    output logic               empty,
    input  logic               pop,
    output logic [15:0]        o_red,
    output logic [15:0]        o_green,
    output logic [15:0]        o_blue,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import stbs_pkg::*;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    logic [8:0] r_width;
    logic [8:0] r_height;
    logic [8:0] w_w;
    logic [8:0] w_h;
    t_reg_idx   w_idx;
    t_qent      w_fent;
    t_qent      w_bent;
    t_qstat     w_qstat;
    logic       w_qpush;
    logic       w_qpop;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (w_idx)
            REG_IMAGE_WIDTH:  prdata = {23'b0, r_width};
            REG_IMAGE_HEIGHT: prdata = {23'b0, r_height};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                REG_IMAGE_WIDTH:  r_width  <= pwdata[8:0];
                REG_IMAGE_HEIGHT: r_height <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // zero counts as one, large values saturate at the maximum
    always_comb begin
        if (r_width == '0) w_w = 9'd1;
        else if (int'(r_width) > MAX_WIDTH) w_w = 9'(MAX_WIDTH);
        else w_w = r_width;
        if (r_height == '0) w_h = 9'd1;
        else if (int'(r_height) > MAX_HEIGHT) w_h = 9'(MAX_HEIGHT);
        else w_h = r_height;
    end

    stbs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_kind          (i_kind),
        .i_texel_address (i_texel_address),
        .i_texel_rgb     (i_texel_rgb),
        .i_dir_x         (i_dir_x),
        .i_dir_y         (i_dir_y),
        .i_dir_z         (i_dir_z),
        .i_qstat         (w_qstat),
        .o_qpush         (w_qpush),
        .o_qent          (w_fent)
    );

    stbs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_qpush),
        .i_ent   (w_fent),
        .i_pop   (w_qpop),
        .o_ent   (w_bent),
        .o_stat  (w_qstat)
    );

    stbs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qent  (w_bent),
        .i_qstat (w_qstat),
        .o_qpop  (w_qpop),
        .i_w     (w_w),
        .i_h     (w_h),
        .i_pop   (pop),
        .o_empty (empty),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

[hdl/stbs_checker.sv]
// ----------------------------------------------------------------------------
// stbs_checker
// port level checks of the sampler, bound to the top level
// ----------------------------------------------------------------------------
module stbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_red,
    input logic [15:0] o_green,
    input logic [15:0] o_blue,
    input logic        pready
);

    // no result survives a reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // input side is open right after reset
    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("full after reset");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_red) && $stable(o_green)
                              && $stable(o_blue)))
        else $error("waiting result changed");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind sphere_texture_bilinear_sample stbs_checker u_stbs_checker (.*);
